FILE: rtl/ir_triac_phase_dimmer_top_assert.svh
// Assertion macros for the dimmer RTL, used by the back end.
`ifndef IR_TRIAC_PHASE_DIMMER_TOP_ASSERT_SVH
`define IR_TRIAC_PHASE_DIMMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITPD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dimmer assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dimmer assertion failed");

`endif

FILE: rtl/itpd_pkg.sv
// Types, constants and register codes of the IR triac phase dimmer.
package itpd_pkg;

    localparam int SYSTEM_BITS_DEF  = 5;
    localparam int COMMAND_BITS_DEF = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] IR_FIRST_SAMPLE_RST = 16'd500;
    localparam logic [15:0] IR_BIT_PERIOD_RST   = 16'd172;
    localparam logic        IR_START_RISING_RST = 1'b1;
    localparam logic [15:0] FIRE_BASE_RST       = 16'd50;
    localparam logic [15:0] FIRE_STEP_RST       = 16'd100;
    localparam logic [3:0]  MAX_LEVEL_RST       = 4'd8;
    localparam logic [15:0] DEBOUNCE_RST        = 16'd10000;
    localparam logic [3:0]  INITIAL_LEVEL_RST   = 4'd0;

    // IR command codes, compared on an 8-bit widened command field.
    localparam logic [7:0] CMD_LEVEL_UP   = 8'd1;
    localparam logic [7:0] CMD_LEVEL_DOWN = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IR_FIRST_SAMPLE = 3'd0,
        CFG_IR_BIT_PERIOD   = 3'd1,
        CFG_IR_START_RISING = 3'd2,
        CFG_FIRE_BASE       = 3'd3,
        CFG_FIRE_STEP       = 3'd4,
        CFG_MAX_LEVEL       = 3'd5,
        CFG_DEBOUNCE        = 3'd6,
        CFG_INITIAL_LEVEL   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic ir_level;
        logic zero_cross_level;
        logic button_up_level;
        logic button_down_level;
    } tick_t;

    typedef struct packed {
        logic       gate_drive;
        logic [3:0] firing_level;
        logic       led_state;
        logic       frame_done;
        logic [4:0] system_address;
        logic [5:0] command_code;
    } result_t;

    // Classified tick, as queued between front and back.
    typedef struct packed {
        logic ir_level;
        logic ir_start;
        logic zc_edge;
        logic up_level;
        logic down_level;
    } tick_class_t;

    // Settings the back end works with.
    typedef struct packed {
        logic [15:0] ir_first_sample_ticks;
        logic [15:0] ir_bit_period_ticks;
        logic [15:0] fire_base_ticks;
        logic [15:0] fire_step_ticks;
        logic [3:0]  max_level;
        logic [15:0] debounce_ticks;
    } cfg_t;

endpackage

FILE: rtl/itpd_front.sv
// Front end: accepts tick words and classifies IR start and zero-cross edges.
module itpd_front
    import itpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    output logic        tick_stall,
    input  tick_t       tick_word,
    input  logic        start_on_rising,
    input  logic        q_full,
    output logic        q_push,
    output tick_class_t q_word
);

    logic prev_ir_reg;
    logic prev_ir_next;
    logic prev_zc_reg;
    logic prev_zc_next;
    logic ir_rise;
    logic ir_fall;

    assign tick_stall = q_full;
    assign q_push     = tick_valid && !q_full;

    assign ir_rise = !prev_ir_reg && tick_word.ir_level;
    assign ir_fall = prev_ir_reg && !tick_word.ir_level;

    always_comb
    begin
        q_word.ir_level   = tick_word.ir_level;
        q_word.ir_start   = start_on_rising ? ir_rise : ir_fall;
        q_word.zc_edge    = tick_word.zero_cross_level ^ prev_zc_reg;
        q_word.up_level   = tick_word.button_up_level;
        q_word.down_level = tick_word.button_down_level;
        prev_ir_next      = q_push ? tick_word.ir_level : prev_ir_reg;
        prev_zc_next      = q_push ? tick_word.zero_cross_level : prev_zc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ir_reg <= 1'b1;
            prev_zc_reg <= 1'b0;
        end
        else
        begin
            prev_ir_reg <= prev_ir_next;
            prev_zc_reg <= prev_zc_next;
        end
    end

endmodule

FILE: rtl/itpd_fifo.sv
// Two-word queue between the front and back ends.
module itpd_fifo
    import itpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tick_class_t push_word,
    output logic        full,
    input  logic        pop,
    output tick_class_t pop_word,
    output logic        empty
);

    tick_class_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/itpd_back.sv
// Back end: IR frame receiver, phase control, buttons and result register.
`include "ir_triac_phase_dimmer_top_assert.svh"

module itpd_back
    import itpd_pkg::*;
#(
    parameter int SYSTEM_BITS  = SYSTEM_BITS_DEF,
    parameter int COMMAND_BITS = COMMAND_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  tick_class_t q_word,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_stall,
    output result_t     res_word
);

    localparam int TOTAL = SYSTEM_BITS + COMMAND_BITS;
    localparam int BC_W  = $clog2(TOTAL + 1);

    function automatic logic [3:0] level_raise(input logic [3:0] lvl, input logic [3:0] top);
        logic [3:0] r;
        r = (lvl >= top) ? top : lvl + 4'd1;
        return r;
    endfunction

    function automatic logic [3:0] level_lower(input logic [3:0] lvl);
        logic [3:0] r;
        r = (lvl != 4'd0) ? lvl - 4'd1 : lvl;
        return r;
    endfunction

    // Returns {release_hit, new_hold_count}.
    function automatic logic [16:0] release_eval(input logic lvl, input logic [15:0] cnt,
                                                 input logic [15:0] deb);
        logic [16:0] r;
        if (!lvl)
        begin
            r = {1'b0, (cnt != 16'hFFFF) ? cnt + 16'd1 : cnt};
        end
        else
        begin
            r = {(cnt != 16'd0) && (cnt >= deb), 16'd0};
        end
        return r;
    endfunction

    logic              frame_active_reg;
    logic              frame_active_next;
    logic [15:0]       frame_timer_reg;
    logic [15:0]       frame_timer_next;
    logic [BC_W-1:0]   bit_count_reg;
    logic [BC_W-1:0]   bit_count_next;
    logic [BC_W-1:0]   bit_count_inc;
    logic [TOTAL-1:0]  frame_shift_reg;
    logic [TOTAL-1:0]  frame_shift_next;
    logic [4:0]        last_system_reg;
    logic [4:0]        last_system_next;
    logic [5:0]        last_command_reg;
    logic [5:0]        last_command_next;
    logic [3:0]        level_reg;
    logic [3:0]        level_next;
    logic [3:0]        level_ir;
    logic [3:0]        level_up_btn;
    logic [19:0]       fire_timer_reg;
    logic [19:0]       fire_timer_next;
    logic [19:0]       fire_delay;
    logic              fire_pending_reg;
    logic              fire_pending_next;
    logic              gate_reg;
    logic              gate_next;
    logic              led_reg;
    logic              led_next;
    logic [15:0]       up_hold_reg;
    logic [15:0]       up_hold_next;
    logic [15:0]       down_hold_reg;
    logic [15:0]       down_hold_next;
    logic [16:0]       up_eval;
    logic [16:0]       down_eval;
    logic [7:0]        cmd_wide;
    logic              done;
    logic              res_valid_reg;
    logic              res_valid_next;
    result_t           res_word_reg;
    result_t           res_word_next;
    logic              last_sample;

    assign q_pop     = !q_empty && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    always_comb
    begin
        frame_active_next = frame_active_reg;
        frame_timer_next  = frame_timer_reg;
        bit_count_next    = bit_count_reg;
        frame_shift_next  = frame_shift_reg;
        last_system_next  = last_system_reg;
        last_command_next = last_command_reg;
        led_next          = led_reg;
        level_ir          = level_reg;
        done              = 1'b0;
        bit_count_inc     = bit_count_reg + BC_W'(1);
        cmd_wide          = 8'd0;

        // Frame receiver: sample when the loaded delay runs out.
        if (frame_active_reg)
        begin
            if (frame_timer_reg <= 16'd1)
            begin
                frame_shift_next = {frame_shift_reg[TOTAL-2:0], q_word.ir_level};
                frame_timer_next = cfg.ir_bit_period_ticks;
                if (bit_count_inc == BC_W'(TOTAL))
                begin
                    cmd_wide          = 8'(frame_shift_next[COMMAND_BITS-1:0]);
                    last_command_next = 6'(frame_shift_next[COMMAND_BITS-1:0]);
                    last_system_next  = 5'(frame_shift_next[TOTAL-1:COMMAND_BITS]);
                    frame_active_next = 1'b0;
                    bit_count_next    = '0;
                    done              = 1'b1;
                    if (cmd_wide == CMD_LEVEL_UP)
                    begin
                        led_next = ~led_reg;
                        level_ir = level_raise(level_reg, cfg.max_level);
                    end
                    else if (cmd_wide == CMD_LEVEL_DOWN)
                    begin
                        led_next = ~led_reg;
                        level_ir = level_lower(level_reg);
                    end
                end
                else
                begin
                    bit_count_next = bit_count_inc;
                end
            end
            else
            begin
                frame_timer_next = frame_timer_reg - 16'd1;
            end
        end
        else if (q_word.ir_start)
        begin
            frame_active_next = 1'b1;
            frame_timer_next  = cfg.ir_first_sample_ticks;
            bit_count_next    = '0;
            frame_shift_next  = '0;
        end

        // Phase control: crossings are ignored while a frame runs.
        fire_delay        = 20'(cfg.fire_base_ticks) + 20'(level_ir) * 20'(cfg.fire_step_ticks);
        gate_next         = gate_reg;
        fire_pending_next = fire_pending_reg;
        fire_timer_next   = fire_timer_reg;
        if (q_word.zc_edge && !frame_active_reg)
        begin
            gate_next         = 1'b0;
            fire_pending_next = q_word.ir_level;
            if (q_word.ir_level)
            begin
                fire_timer_next = fire_delay;
            end
        end
        else if (fire_pending_reg)
        begin
            if (fire_timer_reg <= 20'd1)
            begin
                gate_next         = 1'b1;
                fire_pending_next = 1'b0;
                fire_timer_next   = 20'd0;
            end
            else
            begin
                fire_timer_next = fire_timer_reg - 20'd1;
            end
        end

        // Buttons act after any IR command, up before down.
        up_eval        = release_eval(q_word.up_level, up_hold_reg, cfg.debounce_ticks);
        down_eval      = release_eval(q_word.down_level, down_hold_reg, cfg.debounce_ticks);
        up_hold_next   = up_eval[15:0];
        down_hold_next = down_eval[15:0];
        level_up_btn   = up_eval[16] ? level_raise(level_ir, cfg.max_level) : level_ir;
        level_next     = down_eval[16] ? level_lower(level_up_btn) : level_up_btn;

        res_word_next.gate_drive     = gate_next;
        res_word_next.firing_level   = level_next;
        res_word_next.led_state      = led_next;
        res_word_next.frame_done     = done;
        res_word_next.system_address = last_system_next;
        res_word_next.command_code   = last_command_next;

        if (q_pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_word_reg <= res_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            frame_timer_reg  <= 16'd0;
            bit_count_reg    <= '0;
            frame_shift_reg  <= '0;
            last_system_reg  <= 5'd0;
            last_command_reg <= 6'd0;
            level_reg        <= INITIAL_LEVEL_RST;
            fire_timer_reg   <= 20'd0;
            fire_pending_reg <= 1'b0;
            gate_reg         <= 1'b0;
            led_reg          <= 1'b0;
            up_hold_reg      <= 16'd0;
            down_hold_reg    <= 16'd0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (q_pop)
            begin
                frame_active_reg <= frame_active_next;
                frame_timer_reg  <= frame_timer_next;
                bit_count_reg    <= bit_count_next;
                frame_shift_reg  <= frame_shift_next;
                last_system_reg  <= last_system_next;
                last_command_reg <= last_command_next;
                level_reg        <= level_next;
                fire_timer_reg   <= fire_timer_next;
                fire_pending_reg <= fire_pending_next;
                gate_reg         <= gate_next;
                led_reg          <= led_next;
                up_hold_reg      <= up_hold_next;
                down_hold_reg    <= down_hold_next;
            end
        end
    end

    // Final bit of a frame is due on the next popped word.
    assign last_sample = frame_active_reg && (frame_timer_reg <= 16'd1)
                         && (bit_count_reg == BC_W'(TOTAL - 1));

    `ITPD_ASSERT_IMPLY(a_gate_not_pending, gate_reg, !fire_pending_reg)
    `ITPD_ASSERT_IMPLY(a_done_idle_frame, res_valid && res_word.frame_done, !frame_active_reg)
    `ITPD_ASSERT_IMPLY(a_bit_count_range, frame_active_reg, bit_count_reg < BC_W'(TOTAL))
    `ITPD_ASSERT_NEXT(a_last_bit_done, q_pop && last_sample, res_valid && res_word.frame_done)

endmodule

FILE: rtl/ir_triac_phase_dimmer_top.sv
// Top level of the IR triac phase dimmer: settings registers, front, queue, back.
//
//  channel  dir  handshake               word
//  tick     in   tick_valid / tick_stall tick_word (tick_t): IR, zero-cross, two buttons
//  result   out  res_valid / res_stall   res_word (result_t): gate, level, LED, frame
//  config   in   cfg_valid / cfg_ready   cfg_index, cfg_data: settings register write
//
// One tick word is taken per cycle while tick_stall is low; its result word is presented
// once it has passed a queue slot and then the back end's result register, where a
// result stall can hold it. The back end's update of frame, firing and button state,
// once per popped word, sets the rate.
// Reset (rst_n, async) loads the default settings and the initial firing level of zero.
// A stalled result holds in its register; the two-word queue absorbs the ticks that
// follow, and tick_stall rises once it is full.
module ir_triac_phase_dimmer_top
    import itpd_pkg::*;
#(
    parameter int SYSTEM_BITS  = SYSTEM_BITS_DEF,
    parameter int COMMAND_BITS = COMMAND_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  tick_t                 tick_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        start_rising_reg;
    logic        start_rising_next;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    tick_class_t push_word;
    tick_class_t pop_word;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next          = cfg_reg;
        start_rising_next = start_rising_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IR_FIRST_SAMPLE: cfg_next.ir_first_sample_ticks = cfg_data;
                CFG_IR_BIT_PERIOD:   cfg_next.ir_bit_period_ticks   = cfg_data;
                CFG_IR_START_RISING: start_rising_next              = cfg_data[0];
                CFG_FIRE_BASE:       cfg_next.fire_base_ticks       = cfg_data;
                CFG_FIRE_STEP:       cfg_next.fire_step_ticks       = cfg_data;
                CFG_MAX_LEVEL:       cfg_next.max_level             = cfg_data[3:0];
                CFG_DEBOUNCE:        cfg_next.debounce_ticks        = cfg_data;
                // The initial level only matters at reset, which also restores
                // its default, so drop the write.
                CFG_INITIAL_LEVEL:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ir_first_sample_ticks <= IR_FIRST_SAMPLE_RST;
            cfg_reg.ir_bit_period_ticks   <= IR_BIT_PERIOD_RST;
            cfg_reg.fire_base_ticks       <= FIRE_BASE_RST;
            cfg_reg.fire_step_ticks       <= FIRE_STEP_RST;
            cfg_reg.max_level             <= MAX_LEVEL_RST;
            cfg_reg.debounce_ticks        <= DEBOUNCE_RST;
            start_rising_reg              <= IR_START_RISING_RST;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            start_rising_reg <= start_rising_next;
        end
    end

    // Classify edges on the way in.
    itpd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_valid      (tick_valid),
        .tick_stall      (tick_stall),
        .tick_word       (tick_word),
        .start_on_rising (start_rising_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_word          (push_word)
    );

    // Decouple intake from result stalls.
    itpd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    // Advance receiver, firing and button state one tick per popped word.
    itpd_back #(
        .SYSTEM_BITS  (SYSTEM_BITS),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_word    (pop_word),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule
